[sv/pas_pkg.sv]
// shared types and constants for the polarized azimuth sampler
// no dependencies
`default_nettype none
package pas_pkg;
	localparam int XFRAC = 34;
	localparam int BISECT_STEPS_DEF = 22;
	localparam int SINE_TABLE_DEPTH_DEF = 1024;
	localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
	localparam logic [29:0] INV_45_Q35 = 30'd763549742;
	localparam int HALF_TURN = 4194304;

	// one word in flight through the bisection chain
	typedef struct packed {
		logic [34:0] lo;
		logic [34:0] hi;
		logic [34:0] mid;
		logic [15:0] amag;
		logic        aneg;
		logic        uni;
		logic        sgn;
		logic [15:0] beam;
		logic [23:0] draw;
	} pas_item_t;
endpackage
`default_nettype wire

[sv/pas_cell.sv]
// one bisection step as a six-stage cell: sine lookup, interpolate, scale, compare
// depends on pas_pkg
`default_nettype none
module pas_cell #(
	parameter int Depth = pas_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_v,
	input  wire pas_pkg::pas_item_t in_item,
	output logic                   out_v,
	output pas_pkg::pas_item_t     out_item
);
	import pas_pkg::*;

	localparam int IW = $clog2(Depth + 1);
	localparam int QW = XFRAC + IW + 1;
	localparam logic [QW-1:0] LIM = QW'(Depth) << XFRAC;
	localparam logic [QW-1:0] FULLQ = QW'(2 * Depth) << XFRAC;

	// quarter-wave sine, Q1.30
	logic [30:0] tab [0:Depth];
	for (genvar i = 0; i <= Depth; i++) begin : g_tab
		localparam real ANG = 1.5707963267948966 * i / Depth;
		localparam logic [30:0] V = 31'($rtoi(1073741824.0 * $sin(ANG) + 0.5));
		assign tab[i] = V;
	end

	logic [5:0]  v_q;
	pas_item_t   it_s1, it_s2, it_s3, it_s4, it_s5, it_s6;
	logic [IW-1:0] idx_s1;
	logic [33:0] fr_s1, fr_s2;
	logic [30:0] base_s2, diff_s2, sv_s3;
	logic [46:0] p_s4;
	logic [54:0] mh_s5;
	logic [53:0] ml_s5;

	// stage 1 combinational
	logic [35:0] sum;
	logic [34:0] mid;
	logic [QW-1:0] q, qm;
	pas_item_t nxt_s1;
	always_comb begin
		sum = {1'b0, in_item.lo} + {1'b0, in_item.hi};
		mid = sum[35:1];
		q = QW'(mid) * QW'(2 * Depth);
		qm = (q > LIM) ? FULLQ - q : q;
		nxt_s1 = in_item;
		nxt_s1.mid = mid;
	end

	// stage 2 combinational
	logic [30:0] tlo, thi;
	always_comb begin
		if (idx_s1 >= IW'(Depth)) begin
			tlo = tab[Depth];
			thi = tab[Depth];
		end else begin
			tlo = tab[idx_s1];
			thi = tab[idx_s1 + IW'(1)];
		end
	end

	// stage 3 and 6 combinational
	logic [64:0] ip;
	logic [78:0] tot;
	logic [35:0] cm;
	logic signed [37:0] f;
	pas_item_t nxt_s6;
	always_comb begin
		ip = 65'(diff_s2) * 65'(fr_s2);
		tot = {1'b0, mh_s5, 23'b0} + 79'(ml_s5);
		cm = tot[78:43];
		f = it_s5.aneg ? $signed({3'b0, it_s5.mid}) - $signed({2'b0, cm})
		               : $signed({3'b0, it_s5.mid}) + $signed({2'b0, cm});
		nxt_s6 = it_s5;
		if (f < $signed({4'b0, it_s5.draw, 10'b0}))
			nxt_s6.lo = it_s5.mid;
		else
			nxt_s6.hi = it_s5.mid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[4:0], in_v};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= nxt_s1;
			idx_s1 <= IW'(qm >> XFRAC);
			fr_s1 <= qm[33:0];

			it_s2 <= it_s1;
			fr_s2 <= fr_s1;
			base_s2 <= tlo;
			diff_s2 <= (thi < tlo) ? 31'd0 : thi - tlo;

			it_s3 <= it_s2;
			sv_s3 <= base_s2 + 31'(ip >> XFRAC);

			it_s4 <= it_s3;
			p_s4 <= 47'(it_s3.amag) * 47'(sv_s3);

			it_s5 <= it_s4;
			mh_s5 <= 55'(p_s4[46:23]) * 55'(INV_PI_Q32);
			ml_s5 <= 54'(p_s4[22:0]) * 54'(INV_PI_Q32);

			it_s6 <= nxt_s6;
		end
	end

	assign out_v = v_q[5];
	assign out_item = it_s6;
endmodule
`default_nettype wire

[sv/pas_finish.sv]
// final rounding, sign, beam offset and wrap to minus pi..pi, two stages
// depends on pas_pkg
`default_nettype none
module pas_finish (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_v,
	input  wire pas_pkg::pas_item_t in_item,
	output logic                    out_v,
	output logic signed [23:0]      azimuth
);
	import pas_pkg::*;

	logic [1:0] v_q;
	logic signed [23:0] az_s1;
	logic signed [24:0] bq_s1;
	logic uni_s1;
	logic signed [23:0] az_s2;

	logic [35:0] sum;
	logic [34:0] mid, rnd;
	logic [22:0] mag;
	logic [15:0] bmag;
	logic [29:0] y;
	logic [58:0] prod;
	logic [23:0] bq;
	logic signed [26:0] s;
	logic signed [26:0] r;
	always_comb begin
		sum = {1'b0, in_item.lo} + {1'b0, in_item.hi};
		mid = sum[35:1];
		rnd = mid + 35'd2048;
		mag = rnd[34:12];
		bmag = in_item.beam[15] ? 16'(-in_item.beam) : in_item.beam;
		y = 30'((31'(bmag) * 31'd32768 + 31'd45) >> 1);
		prod = 59'(y) * 59'(INV_45_Q35);
		bq = 24'(prod >> 35);
		s = 27'(az_s1) + 27'(bq_s1);
		r = 27'($signed(s[22:0]));
		if (s[22:0] == 23'h400000)
			r = (s > 0) ? 27'(HALF_TURN) : -27'(HALF_TURN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[0], in_v};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			uni_s1 <= in_item.uni;
			if (in_item.uni)
				az_s1 <= 24'(in_item.draw >> 1) - 24'(HALF_TURN);
			else if (in_item.sgn)
				az_s1 <= 24'(mag);
			else
				az_s1 <= -24'(mag);
			bq_s1 <= in_item.beam[15] ? -25'(bq) : 25'(bq);
			az_s2 <= uni_s1 ? az_s1 : 24'(r);
		end
	end

	assign out_v = v_q[1];
	assign azimuth = az_s2;
endmodule
`default_nettype wire

[sv/polarized_azimuth_sampler.sv]
// polarized azimuth sampler: inverse-cdf bisection, one cell per step
// one word accepted per cycle while in_stall is low
// the whole pipeline holds while a finished word waits under out_stall
// arst_n clears all valid bits; payload registers are not reset
// depends on pas_pkg, pas_cell, pas_finish
`default_nettype none
module polarized_azimuth_sampler #(
	parameter int BISECT_STEPS = pas_pkg::BISECT_STEPS_DEF,
	parameter int SINE_TABLE_DEPTH = pas_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] analyzing_power,
	input  wire logic signed [15:0] beam_angle,
	input  wire logic [23:0]        uniform_draw,
	input  wire logic               sign_draw,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [23:0]      azimuth
);
	import pas_pkg::*;

	// global advance: everything moves unless the output word is held
	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	// entry word: bisection interval [0, 1] in Q1.34 of pi
	pas_item_t entry;
	always_comb begin
		entry.lo = '0;
		entry.hi = 35'h4_0000_0000;
		entry.mid = '0;
		entry.amag = analyzing_power[15] ? 16'(-analyzing_power) : analyzing_power;
		entry.aneg = analyzing_power[15];
		entry.uni = (analyzing_power == 16'sd0);
		entry.sgn = sign_draw;
		entry.beam = beam_angle;
		entry.draw = uniform_draw;
	end

	// chain of identical bisection cells
	logic      v_c [0:BISECT_STEPS];
	pas_item_t it_c [0:BISECT_STEPS];
	assign v_c[0] = in_valid;
	assign it_c[0] = entry;

	for (genvar k = 0; k < BISECT_STEPS; k++) begin : g_cell
		pas_cell #(.Depth(SINE_TABLE_DEPTH)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_v    (v_c[k]),
			.in_item (it_c[k]),
			.out_v   (v_c[k+1]),
			.out_item(it_c[k+1])
		);
	end

	// rounding, half-plane, beam offset and wrap
	pas_finish u_finish (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_c[BISECT_STEPS]),
		.in_item(it_c[BISECT_STEPS]),
		.out_v  (out_valid),
		.azimuth(azimuth)
	);
endmodule
`default_nettype wire

[tb/pas_checker.sv]
// scoreboard for the polarized azimuth sampler: watches both channels, predicts each azimuth
// rebuilds the quarter-wave sine table itself; no dependencies besides the block's port widths
`default_nettype none
module pas_checker #(
	parameter int BISECT_STEPS = 22,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic signed [15:0] analyzing_power,
	input  wire logic signed [15:0] beam_angle,
	input  wire logic [23:0]        uniform_draw,
	input  wire logic               sign_draw,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic signed [23:0] azimuth,
	output int                      errors,
	output int                      pending,
	output int                      checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;
	localparam logic [63:0] INV_PI_K = 64'd1367130551;

	logic [31:0] sine_rom [0:SINE_TABLE_DEPTH];
	logic [23:0] azimuth_fifo [$];

	function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
			input int s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> s;
		return p[63:0];
	endfunction

	initial begin
		logic [63:0] stp, rem, t, t2, term, sum, dd;
		dd = SINE_TABLE_DEPTH;
		stp = HALF_PI_Q60 / dd;
		rem = HALF_PI_Q60 % dd;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			t = stp * i + (rem * i) / dd;
			t2 = mul_shift(t, t, 60);
			term = t;
			sum = t;
			for (int k = 1; k <= 13; k++) begin
				term = mul_shift(term, t2, 60) / (64'(2 * k) * 64'(2 * k + 1));
				if (k & 1)
					sum = sum - term;
				else
					sum = sum + term;
			end
			sine_rom[i] = 32'((sum + (64'd1 << 29)) >> 30);
		end
	end

	// sin(pi*x/2^34) in q1.30, mirrored about pi/2, truncated interpolation
	function automatic logic [63:0] sine_of(input logic [63:0] x);
		logic [63:0] dd, q, idx, fr, lo, hi;
		dd = SINE_TABLE_DEPTH;
		q = x * (2 * dd);
		if (q > (dd << 34))
			q = ((2 * dd) << 34) - q;
		idx = q >> 34;
		fr = q & ((64'd1 << 34) - 1);
		if (idx >= dd)
			return 64'(sine_rom[SINE_TABLE_DEPTH]);
		lo = sine_rom[idx];
		hi = sine_rom[idx + 1];
		if (hi < lo)
			return lo;
		return lo + (((hi - lo) * fr) >> 34);
	endfunction

	function automatic logic [23:0] predict_azimuth(input logic signed [15:0] pw,
			input logic signed [15:0] beam, input logic [23:0] u, input logic sg);
		longint a, b, az, bq, f, target;
		logic [63:0] lo, hi, mid, amag, bmag, cm;
		a = pw;
		b = beam;
		if (a == 0)
			return 24'(longint'(u >> 1) - 4194304);
		amag = a < 0 ? -a : a;
		target = longint'(u) << 10;
		lo = 0;
		hi = 64'd1 << 34;
		for (int n = 0; n < BISECT_STEPS; n++) begin
			mid = (lo + hi) >> 1;
			cm = mul_shift(amag * sine_of(mid), INV_PI_K, 43);
			f = a < 0 ? longint'(mid) - longint'(cm) : longint'(mid) + longint'(cm);
			if (f < target)
				lo = mid;
			else
				hi = mid;
		end
		mid = (lo + hi) >> 1;
		az = longint'((mid + (64'd1 << 11)) >> 12);
		if (!sg)
			az = -az;
		bmag = b < 0 ? -b : b;
		bq = longint'((bmag * 32768 + 45) / 90);
		az = az + (b < 0 ? -bq : bq);
		while (az > 4194304)
			az = az - 8388608;
		while (az < -4194304)
			az = az + 8388608;
		return 24'(az);
	endfunction

	assign pending = azimuth_fifo.size();

	always @(posedge clk or negedge arst_n) begin
		logic [23:0] want;
		if (!arst_n) begin
			errors <= 0;
			checked <= 0;
		end else begin
			if (in_valid && !in_stall)
				azimuth_fifo.push_back(predict_azimuth(analyzing_power, beam_angle,
					uniform_draw, sign_draw));
			if (out_valid && !out_stall) begin
				if (azimuth_fifo.size() == 0) begin
					if (errors < 10)
						$display("unexpected azimuth word %0d", azimuth);
					errors <= errors + 1;
				end else begin
					want = azimuth_fifo.pop_front();
					if (want !== azimuth) begin
						if (errors < 10)
							$display("azimuth mismatch: expected %0d got %0d",
								$signed(want), azimuth);
						errors <= errors + 1;
					end
					checked <= checked + 1;
				end
			end
		end
	end
endmodule
`default_nettype wire

[tb/tb_polarized_azimuth_sampler.sv]
// top of the polarized azimuth sampler testbench: clock, reset, stimulus and verdict
// depends on polarized_azimuth_sampler (with pas_pkg) and pas_checker
`default_nettype none
module tb_polarized_azimuth_sampler;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] analyzing_power = '0;
	logic signed [15:0] beam_angle = '0;
	logic [23:0] uniform_draw = '0;
	logic sign_draw = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [23:0] azimuth;
	int errors, pending, checked;
	int stall_mode = 0;

	always #5 clk = ~clk;

	polarized_azimuth_sampler dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.analyzing_power(analyzing_power), .beam_angle(beam_angle),
		.uniform_draw(uniform_draw), .sign_draw(sign_draw),
		.out_valid(out_valid), .out_stall(out_stall), .azimuth(azimuth)
	);

	pas_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.analyzing_power(analyzing_power), .beam_angle(beam_angle),
		.uniform_draw(uniform_draw), .sign_draw(sign_draw),
		.out_valid(out_valid), .out_stall(out_stall), .azimuth(azimuth),
		.errors(errors), .pending(pending), .checked(checked)
	);

	// receiver stall pattern: modes switch every so often, mode 0 never stalls
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// present one word and hold it until the block takes it
	task automatic send_word(input logic signed [15:0] pw, input logic signed [15:0] beam,
			input logic [23:0] u, input logic sg);
		bit taken;
		in_valid <= 1'b1;
		analyzing_power <= pw;
		beam_angle <= beam;
		uniform_draw <= u;
		sign_draw <= sg;
		taken = 0;
		while (!taken) begin
			// stall only changes at rising edges, so its value at the falling edge holds
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
	endtask

	// idle the sender after a word, unless n is zero
	task automatic sender_gap(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_pipe;
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int burst;
		logic signed [15:0] pw, beam;
		logic signed [15:0] pw_set [6];
		logic signed [15:0] beam_set [6];
		logic [23:0] draw_set [4];

		pw_set = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd1, -16'sd1, 16'sd16384};
		beam_set = '{-16'sd32768, 16'sd32767, -16'sd23040, 16'sd23040, 16'sd0, 16'sd5760};
		draw_set = '{24'd0, 24'hFFFFFF, 24'd1, 24'h800000};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme powers, beams and draws, both half-planes, uniform mode
		for (int i = 0; i < 24; i++) begin
			send_word(pw_set[i % 6], beam_set[(i / 2) % 6], draw_set[i % 4], i[2]);
			sender_gap(i % 3);
		end

		// random bursts; hold off once midway until every result has come back
		burst = 0;
		for (int i = 0; i < 830; i++) begin
			case ($urandom_range(0, 9))
				0: pw = '0;
				1: pw = $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
				default: pw = 16'($urandom);
			endcase
			if ($urandom_range(0, 7) == 0)
				beam = 16'($urandom);
			else
				beam = 16'(int'($urandom_range(0, 46080)) - 23040);
			send_word(pw, beam, 24'($urandom), 1'($urandom_range(0, 1)));
			if (i == 400)
				drain_pipe;
			else if (burst == 0) begin
				burst = $urandom_range(1, 40);
				sender_gap($urandom_range(1, 12));
			end else
				burst--;
		end

		drain_pipe;
		repeat (200) @(posedge clk);
		$display("run covered 854 words: extreme and uniform-mode powers, wrapped beams,");
		$display("%0d azimuth words compared under random sender gaps and receiver stalls",
			checked);
		if (errors == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog well past the slowest expected run
	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
`default_nettype wire
